/* rtl/pip_pkg.sv */
// Shared constants for the point-in-polygon test block.
// No dependencies; compiled before every other file of the block.
package pip_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int CNT_BITS = 2;
  localparam logic [CNT_BITS-1:0] MIN_VERTICES = CNT_BITS'(3);
  localparam int QUEUE_DEPTH = 2;

endpackage

/* rtl/pip_in_if.sv */
// Valid/ready channel carrying one polygon vertex item and its query point.
// Depends on pip_pkg for the default coordinate width.
interface pip_in_if #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic                         last_vertex;

  modport source (output valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
                  input ready);
  modport sink (input valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
                output ready);
endinterface

/* rtl/pip_out_if.sv */
// Valid/ready channel carrying one point-in-polygon result item.
// No dependencies.
interface pip_out_if ();
  logic valid;
  logic ready;
  logic inside_res;
  logic too_few_vertices;

  modport source (output valid, inside_res, too_few_vertices, input ready);
  modport sink (input valid, inside_res, too_few_vertices, output ready);
endinterface

/* rtl/pip_front.sv */
// Front end: accepts vertex items, keeps the first and previous vertex and the count,
// and turns each item into its edge jobs. Depends on pip_pkg and pip_in_if.
module pip_front #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
  parameter int ENTRY_BITS = 2 * (4 * (COORD_BITS + 1) + 1) + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  pip_in_if.sink                points,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [ENTRY_BITS-1:0] push_data
);
  import pip_pkg::*;

  localparam int D = COORD_BITS + 1;

  typedef struct packed {
    logic                en;
    logic signed [D-1:0] dxq;
    logic signed [D-1:0] dy;
    logic signed [D-1:0] dxe;
    logic signed [D-1:0] dqy;
  } edge_job_t;

  typedef struct packed {
    edge_job_t e0;
    edge_job_t e1;
    logic      last;
    logic      too_few;
  } job_t;

  function automatic edge_job_t make_job(
    input logic signed [COORD_BITS-1:0] ax,
    input logic signed [COORD_BITS-1:0] ay,
    input logic signed [COORD_BITS-1:0] bx,
    input logic signed [COORD_BITS-1:0] by,
    input logic signed [COORD_BITS-1:0] qx,
    input logic signed [COORD_BITS-1:0] qy
  );
    edge_job_t           j;
    logic signed [D-1:0] dy;
    logic signed [D-1:0] dqy;
    dy = D'(by) - D'(ay);
    dqy = D'(qy) - D'(ay);
    j.en = (ay > qy) != (by > qy);
    j.dxq = D'(qx) - D'(ax);
    j.dxe = D'(bx) - D'(ax);
    j.dy = dy[D-1] ? -dy : dy;
    j.dqy = dy[D-1] ? -dqy : dqy;
    return j;
  endfunction

  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic [CNT_BITS-1:0]          cnt;
  logic [CNT_BITS-1:0]          cnt_next;
  logic                         is_first;
  logic                         accept;
  job_t                         job;

  assign is_first = (cnt == '0);
  assign cnt_next = (cnt < MIN_VERTICES) ? cnt + CNT_BITS'(1) : cnt;
  assign accept = points.valid && push_ready;

  always_comb begin
    job.e0 = make_job(points.vertex_x, points.vertex_y, prev_x, prev_y,
                      points.query_x, points.query_y);
    job.e0.en = job.e0.en && !is_first;
    job.last = points.last_vertex;
    job.too_few = cnt_next < MIN_VERTICES;
    job.e1 = make_job(first_x, first_y, points.vertex_x, points.vertex_y,
                      points.query_x, points.query_y);
    job.e1.en = job.e1.en && points.last_vertex && !job.too_few;
  end

  assign push_valid = points.valid;
  assign points.ready = push_ready;
  assign push_data = ENTRY_BITS'(job);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      first_x <= '0;
      first_y <= '0;
      prev_x <= '0;
      prev_y <= '0;
    end else if (accept) begin
      if (is_first) begin
        first_x <= points.vertex_x;
        first_y <= points.vertex_y;
      end
      prev_x <= points.vertex_x;
      prev_y <= points.vertex_y;
      cnt <= points.last_vertex ? '0 : cnt_next;
    end
  end

endmodule

/* rtl/pip_queue.sv */
// Two-entry queue of edge jobs between the front end and the back end.
// Depends on pip_pkg for the queue depth.
module pip_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  import pip_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]     mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [FILL_BITS-1:0] fill;
  logic                 push;
  logic                 pop;

  assign in_ready = fill != FILL_BITS'(QUEUE_DEPTH);
  assign out_valid = fill != '0;
  assign out_data = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_BITS'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_BITS'(1);
      end
    end
  end

endmodule

/* rtl/pip_back.sv */
// Back end: multiplies the cross-product terms of each item's edge jobs, compares them,
// keeps the crossing parity and holds the result register. Depends on pip_pkg, pip_out_if.
module pip_back #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
  parameter int ENTRY_BITS = 2 * (4 * (COORD_BITS + 1) + 1) + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  logic [ENTRY_BITS-1:0] pop_data,
  pip_out_if.source             result
);
  import pip_pkg::*;

  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D;

  typedef struct packed {
    logic                en;
    logic signed [D-1:0] dxq;
    logic signed [D-1:0] dy;
    logic signed [D-1:0] dxe;
    logic signed [D-1:0] dqy;
  } edge_job_t;

  typedef struct packed {
    edge_job_t e0;
    edge_job_t e1;
    logic      last;
    logic      too_few;
  } job_t;

  job_t                job;
  logic                advance;
  logic                m_valid;
  logic                m_en0;
  logic                m_en1;
  logic                m_last;
  logic                m_too_few;
  logic signed [P-1:0] m_lhs0;
  logic signed [P-1:0] m_rhs0;
  logic signed [P-1:0] m_lhs1;
  logic signed [P-1:0] m_rhs1;
  logic                parity;
  logic                parity_next;

  assign job = job_t'(pop_data);
  assign advance = !(m_valid && m_last && result.valid && !result.ready);
  assign pop_ready = advance;
  assign parity_next = parity ^ (m_en0 && (m_lhs0 < m_rhs0)) ^ (m_en1 && (m_lhs1 < m_rhs1));

  always_ff @(posedge clk) begin
    if (advance && pop_valid) begin
      m_en0 <= job.e0.en;
      m_en1 <= job.e1.en;
      m_last <= job.last;
      m_too_few <= job.too_few;
      m_lhs0 <= P'(job.e0.dxq) * P'(job.e0.dy);
      m_rhs0 <= P'(job.e0.dxe) * P'(job.e0.dqy);
      m_lhs1 <= P'(job.e1.dxq) * P'(job.e1.dy);
      m_rhs1 <= P'(job.e1.dxe) * P'(job.e1.dqy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      parity <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (advance) begin
        m_valid <= pop_valid;
      end
      if (advance && m_valid) begin
        parity <= m_last ? 1'b0 : parity_next;
      end
      if (advance && m_valid && m_last) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && m_valid && m_last) begin
      result.inside_res <= !m_too_few && parity_next;
      result.too_few_vertices <= m_too_few;
    end
  end

endmodule

/* rtl/point_in_polygon_test.sv */
// Even-odd point-in-polygon test: top level joining front end, job queue and back end.
// Depends on pip_pkg, pip_in_if, pip_out_if, pip_front, pip_queue and pip_back.
//
// The polygon arrives on the points channel one vertex per item, each item carrying the
// query point and a mark on the final vertex. One result item leaves on the result
// channel for each final vertex: inside_res by the even-odd rule, or too_few_vertices
// when the polygon had fewer than three vertices.
// Throughput is one vertex item per clock cycle while points.ready is high; each item's
// edge tests run in parallel in the back end, with a multiplier pair for each edge.
// A final vertex accepted into the queue passes the product register, then the result
// register, before its result is valid.
// A two-entry queue separates the front end from the back end. When the receiver stalls,
// the result register holds; items with no result keep flowing through the back end,
// and the next final vertex waits in the product stage, then the queue fills and
// points.ready falls.
// Synchronous reset clears the vertex count, stored vertices, parity, queue and all
// valid flags; the block is ready on the cycle after reset is released.
module point_in_polygon_test #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  pip_in_if.sink    points,
  pip_out_if.source result
);
  import pip_pkg::*;

  localparam int ENTRY_BITS = 2 * (4 * (COORD_BITS + 1) + 1) + 2;

  logic                  push_valid;
  logic                  push_ready;
  logic [ENTRY_BITS-1:0] push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [ENTRY_BITS-1:0] pop_data;

  pip_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .points     (points),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pip_queue #(
    .WIDTH (ENTRY_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  pip_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule
